// File: rtl/core/rth_pkg.sv
`timescale 1ns / 1ps
package rth_pkg;

  // Field and datapath widths
  localparam int COLOR_W = 8;
  localparam int HUE_W   = 8;
  localparam int SQ_W    = 18;   // anum^2 and 4*d both fit below 2^18
  localparam int COS_W   = 32;   // signed Q2.30
  localparam int HUE_N   = 256;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1 <<< 30;

  // Sideband that travels with each pixel
  typedef struct packed {
    logic neg;
    logic gray;
    logic last;
  } rth_tag_t;

  // cos(k*pi/255) in Q2.30, Taylor series through the x^16 term.
  // Used only at elaboration to build the threshold table.
  function automatic logic signed [COS_W-1:0] cos_q30(input int unsigned k);
    longint kk;
    longint x;
    longint x2;
    longint term;
    longint sum;
    logic   neg;
    kk  = longint'(k & 255);
    neg = 1'b0;
    if (kk >= 128) begin
      kk  = 255 - kk;
      neg = 1'b1;
    end
    x    = (kk * PI_Q30) / 255;
    x2   = (x * x) >>> 30;
    term = ONE_Q30;
    sum  = term;
    term = ((term * x2) >>> 30) / 2;   sum = sum - term;
    term = ((term * x2) >>> 30) / 12;  sum = sum + term;
    term = ((term * x2) >>> 30) / 30;  sum = sum - term;
    term = ((term * x2) >>> 30) / 56;  sum = sum + term;
    term = ((term * x2) >>> 30) / 90;  sum = sum - term;
    term = ((term * x2) >>> 30) / 132; sum = sum + term;
    term = ((term * x2) >>> 30) / 182; sum = sum - term;
    term = ((term * x2) >>> 30) / 240; sum = sum + term;
    if (neg) begin
      sum = -sum;
    end
    return COS_W'(sum);
  endfunction

endpackage

// File: rtl/core/rth_front.sv
`timescale 1ns / 1ps
module rth_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  logic [rth_pkg::COLOR_W-1:0]       red_i,
  input  logic [rth_pkg::COLOR_W-1:0]       green_i,
  input  logic [rth_pkg::COLOR_W-1:0]       blue_i,
  input  logic                              last_i,
  output logic                              vld_o,
  output logic [rth_pkg::SQ_W-1:0]          n_o,
  output logic [rth_pkg::SQ_W-1:0]          den_o,
  output rth_pkg::rth_tag_t                 tag_o
);

  logic signed [9:0]  rg, rb, gb;
  logic signed [10:0] num;
  logic [8:0]         anum;
  logic signed [17:0] p1, p2;
  logic signed [18:0] d;

  logic               vld1_r;
  logic [8:0]         anum1_r;
  logic               neg1_r;
  logic               last1_r;
  logic signed [17:0] p1_r, p2_r;

  logic               vld2_r;
  logic [rth_pkg::SQ_W-1:0] n2_r, den2_r;
  rth_pkg::rth_tag_t  tag2_r;

  // Stage 1: differences and the two products of d
  always_comb begin
    rg   = $signed({2'b00, red_i}) - $signed({2'b00, green_i});
    rb   = $signed({2'b00, red_i}) - $signed({2'b00, blue_i});
    gb   = $signed({2'b00, green_i}) - $signed({2'b00, blue_i});
    num  = $signed({2'b00, red_i, 1'b0}) - $signed({3'b000, green_i})
         - $signed({3'b000, blue_i});
    anum = num[10] ? 9'(-num) : num[8:0];
    p1   = 18'(20'(rg) * 20'(rg));
    p2   = 18'(20'(rb) * 20'(gb));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    anum1_r <= anum;
    neg1_r  <= num[10];
    last1_r <= last_i;
    p1_r    <= p1;
    p2_r    <= p2;
  end

  // Stage 2: d, 4*d, anum^2 and the gray flag
  always_comb begin
    d = 19'(p1_r) + 19'(p2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    n2_r        <= rth_pkg::SQ_W'(anum1_r) * rth_pkg::SQ_W'(anum1_r);
    den2_r      <= {d[15:0], 2'b00};
    tag2_r.neg  <= neg1_r;
    tag2_r.gray <= (d <= 19'sd0);
    tag2_r.last <= last1_r;
  end

  assign vld_o = vld2_r;
  assign n_o   = n2_r;
  assign den_o = den2_r;
  assign tag_o = tag2_r;

endmodule

// File: rtl/core/rth_div.sv
`timescale 1ns / 1ps
module rth_div #(
  parameter int F = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  logic [rth_pkg::SQ_W-1:0]    n_i,
  input  logic [rth_pkg::SQ_W-1:0]    den_i,
  input  rth_pkg::rth_tag_t           tag_i,
  output logic                        vld_o,
  output logic [2*F:0]                q_o,
  output rth_pkg::rth_tag_t           tag_o
);

  localparam int NS = 2 * F + 1;
  localparam int SW = rth_pkg::SQ_W;

  logic [SW-1:0]     rem_r [NS];
  logic [SW-1:0]     den_r [NS];
  logic [2*F:0]      q_r   [NS];
  logic              vld_r [NS];
  rth_pkg::rth_tag_t tag_r [NS];

  logic              ip;

  // Integer part: n never exceeds den, so one compare settles it
  assign ip = (n_i >= den_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= ip ? (n_i - den_i) : n_i;
    den_r[0] <= den_i;
    q_r[0]   <= {{(2*F){1'b0}}, ip};
    tag_r[0] <= tag_i;
  end

  // One restoring quotient bit per stage
  for (genvar s = 1; s < NS; s++) begin : g_stage
    logic [SW:0]   rem2;
    logic          ge;
    logic [SW-1:0] rem_nxt;

    always_comb begin
      rem2    = {rem_r[s-1], 1'b0};
      ge      = (rem2 >= {1'b0, den_r[s-1]});
      rem_nxt = ge ? SW'(rem2 - {1'b0, den_r[s-1]}) : rem2[SW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      den_r[s] <= den_r[s-1];
      q_r[s]   <= {q_r[s-1][2*F-1:0], ge};
      tag_r[s] <= tag_r[s-1];
    end
  end

  assign vld_o = vld_r[NS-1];
  assign q_o   = q_r[NS-1];
  assign tag_o = tag_r[NS-1];

endmodule

// File: rtl/core/rth_sqrt.sv
`timescale 1ns / 1ps
module rth_sqrt #(
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  logic [2*F:0]        sq_i,
  input  rth_pkg::rth_tag_t   tag_i,
  output logic                vld_o,
  output logic [F:0]          mag_o,
  output rth_pkg::rth_tag_t   tag_o
);

  localparam int NS = F + 1;
  localparam int W  = 2 * F + 2;

  logic [W-1:0]      v_r   [NS];
  logic [W-1:0]      res_r [NS];
  logic              vld_r [NS];
  rth_pkg::rth_tag_t tag_r [NS];

  // Digit-by-digit root, one result bit per stage
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (2 * (F - s));
    logic [W-1:0]      v_in, res_in, trial;
    logic              vld_in;
    rth_pkg::rth_tag_t tag_in;
    logic [W-1:0]      v_nxt, res_nxt;

    if (s == 0) begin : g_first
      assign v_in   = W'(sq_i);
      assign res_in = '0;
      assign vld_in = vld_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign res_in = res_r[s-1];
      assign vld_in = vld_r[s-1];
      assign tag_in = tag_r[s-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (v_in >= trial) begin
        v_nxt   = v_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        v_nxt   = v_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      v_r[s]   <= v_nxt;
      res_r[s] <= res_nxt;
      tag_r[s] <= tag_in;
    end
  end

  assign vld_o = vld_r[NS-1];
  assign mag_o = res_r[NS-1][F:0];
  assign tag_o = tag_r[NS-1];

endmodule

// File: rtl/core/rth_search.sv
`timescale 1ns / 1ps
module rth_search #(
  parameter int F = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [F:0]                    mag_i,
  input  rth_pkg::rth_tag_t             tag_i,
  output logic                          vld_o,
  output logic [rth_pkg::HUE_W-1:0]     hue_o,
  output rth_pkg::rth_tag_t             tag_o
);

  localparam int HW = rth_pkg::HUE_W;
  localparam int CW = rth_pkg::COS_W;
  localparam int NS = HW + 1;

  logic signed [CW-1:0] tbl [rth_pkg::HUE_N];

  logic signed [CW-1:0] ratio_r [NS];
  logic [HW-1:0]        k_r     [NS];
  logic                 vld_r   [NS];
  rth_pkg::rth_tag_t    tag_r   [NS];

  logic signed [CW-1:0] pos;

  // Cosine threshold table, fixed at elaboration
  for (genvar g = 0; g < rth_pkg::HUE_N; g++) begin : g_tbl
    localparam logic signed [CW-1:0] C = rth_pkg::cos_q30(g);
    assign tbl[g] = C;
  end

  // Stage 0: signed ratio in Q2.30
  assign pos = $signed(CW'(mag_i) << (30 - F));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    ratio_r[0] <= tag_i.neg ? -pos : pos;
    k_r[0]     <= '0;
    tag_r[0]   <= tag_i;
  end

  // One code bit per stage, most significant first
  for (genvar s = 1; s < NS; s++) begin : g_stage
    localparam int B = HW - s;
    logic [HW-1:0] cand;
    logic          ge;

    always_comb begin
      cand = k_r[s-1] | (HW'(1) << B);
      ge   = (tbl[cand] >= ratio_r[s-1]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      ratio_r[s] <= ratio_r[s-1];
      k_r[s]     <= ge ? cand : k_r[s-1];
      tag_r[s]   <= tag_r[s-1];
    end
  end

  assign vld_o = vld_r[NS-1];
  assign hue_o = tag_r[NS-1].gray ? '0 : k_r[NS-1];
  assign tag_o = tag_r[NS-1];

endmodule

// File: rtl/core/rgb_to_hue_angle.sv
`timescale 1ns / 1ps
// Hue angle of an 8-bit RGB pixel, 0..pi mapped to codes 0..255 (no fold past
// pi). A pixel is taken on every cycle that start is high; busy is always low.
// Each result appears for one cycle with out_strobe after it passes through two
// front stages, one divider stage per quotient bit (2F+1), one square-root stage
// per root bit (F+1), nine search stages and the output register. Results cannot
// be held off. Gray pixels give hue 0 with out_is_gray set.
module rgb_to_hue_angle #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rth_pkg::COLOR_W-1:0]   in_red,
  input  logic [rth_pkg::COLOR_W-1:0]   in_green,
  input  logic [rth_pkg::COLOR_W-1:0]   in_blue,
  input  logic                          in_last_pixel,
  output logic                          out_strobe,
  output logic [rth_pkg::HUE_W-1:0]     out_hue,
  output logic                          out_is_gray,
  output logic                          out_last_out
);

  localparam int F   = RATIO_FRAC_BITS;
  localparam int LAT = 3 * F + 14;

  logic                          fr_vld, dv_vld, sq_vld, sr_vld;
  logic [rth_pkg::SQ_W-1:0]      fr_n, fr_den;
  logic [2*F:0]                  dv_q;
  logic [F:0]                    sq_mag;
  logic [rth_pkg::HUE_W-1:0]     sr_hue;
  rth_pkg::rth_tag_t             fr_tag, dv_tag, sq_tag, sr_tag;
  logic                          acc;

  logic                          strobe_r;
  logic [rth_pkg::HUE_W-1:0]     hue_r;
  logic                          gray_r, last_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  rth_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (acc),
    .red_i   (in_red),
    .green_i (in_green),
    .blue_i  (in_blue),
    .last_i  (in_last_pixel),
    .vld_o   (fr_vld),
    .n_o     (fr_n),
    .den_o   (fr_den),
    .tag_o   (fr_tag)
  );

  rth_div #(.F(F)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (fr_vld),
    .n_i   (fr_n),
    .den_i (fr_den),
    .tag_i (fr_tag),
    .vld_o (dv_vld),
    .q_o   (dv_q),
    .tag_o (dv_tag)
  );

  rth_sqrt #(.F(F)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (dv_vld),
    .sq_i  (dv_q),
    .tag_i (dv_tag),
    .vld_o (sq_vld),
    .mag_o (sq_mag),
    .tag_o (sq_tag)
  );

  rth_search #(.F(F)) u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (sq_vld),
    .mag_i (sq_mag),
    .tag_i (sq_tag),
    .vld_o (sr_vld),
    .hue_o (sr_hue),
    .tag_o (sr_tag)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= sr_vld;
    end
  end

  always_ff @(posedge clk) begin
    hue_r  <= sr_hue;
    gray_r <= sr_tag.gray;
    last_r <= sr_tag.last;
  end

  assign out_strobe   = strobe_r;
  assign out_hue      = hue_r;
  assign out_is_gray  = gray_r;
  assign out_last_out = last_r;

  // Gray pixels always report code zero
  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_gray |-> out_hue == '0)
    else $error("gray pixel with nonzero hue");

  // Every transfer in gives a result a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_strobe)
    else $error("result missing at pipeline latency");

  // No result without a transfer in at the matching cycle
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc, LAT))
    else $error("result without matching input");

endmodule

// File: tb/tb_rgb_to_hue_angle.sv
`timescale 1ns / 1ps
module tb_rgb_to_hue_angle;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = 3 * FRAC_BITS + 14;

  typedef struct {
    logic [rth_pkg::HUE_W-1:0] hue;
    logic                      gray;
    logic                      last;
  } hue_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [rth_pkg::COLOR_W-1:0]   in_red;
  logic [rth_pkg::COLOR_W-1:0]   in_green;
  logic [rth_pkg::COLOR_W-1:0]   in_blue;
  logic                          in_last_pixel;
  logic                          out_strobe;
  logic [rth_pkg::HUE_W-1:0]     out_hue;
  logic                          out_is_gray;
  logic                          out_last_out;

  hue_result_t pending_hues[$];
  longint      cos_thresh[rth_pkg::HUE_N];
  int          err_count;
  int          pixels_sent;
  int          hues_checked;
  int          gray_seen;

  rgb_to_hue_angle #(.RATIO_FRAC_BITS(FRAC_BITS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .in_last_pixel(in_last_pixel), .out_strobe(out_strobe),
    .out_hue(out_hue), .out_is_gray(out_is_gray), .out_last_out(out_last_out)
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cosine threshold, Q2.30, truncated Taylor series
  function automatic longint cos_thresh_calc(input int k);
    longint x, x2, term, sum;
    int     kk;
    bit     flip;
    kk   = k;
    flip = 1'b0;
    if (kk >= 128) begin
      kk   = 255 - kk;
      flip = 1'b1;
    end
    x    = (longint'(kk) * 64'sd3373259426) / 255;
    x2   = (x * x) >>> 30;
    term = 64'sd1 <<< 30;
    sum  = term;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >>> 30) / ((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum -= term;
      else sum += term;
    end
    return flip ? -sum : sum;
  endfunction

  // Expected hue of one pixel
  function automatic hue_result_t predict_hue(input logic [7:0] r, g, b, input logic lst);
    hue_result_t res;
    longint num, d, den, anum, rem, ip, frac, sq, mag, root, bitv, ratio;
    int     lo, hi, mid;
    res.hue  = '0;
    res.gray = 1'b0;
    res.last = lst;
    num = 2 * longint'(r) - longint'(g) - longint'(b);
    d   = (longint'(r) - g) * (longint'(r) - g) + (longint'(r) - b) * (longint'(g) - b);
    if (d <= 0) begin
      res.gray = 1'b1;
      return res;
    end
    den  = 4 * d;
    anum = num < 0 ? -num : num;
    rem  = anum * anum;
    ip   = rem / den;
    rem  = rem % den;
    frac = 0;
    for (int i = 0; i < 2 * FRAC_BITS; i++) begin
      rem  = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem  -= den;
        frac |= 1;
      end
    end
    if (ip > 1) ip = 1;
    sq = (ip << (2 * FRAC_BITS)) + frac;
    // integer square root
    root = 0;
    bitv = 64'sd1 <<< 60;
    while (bitv > sq) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (sq >= root + bitv) begin
        sq  -= root + bitv;
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    mag = root > (64'sd1 <<< FRAC_BITS) ? (64'sd1 <<< FRAC_BITS) : root;
    ratio = mag <<< (30 - FRAC_BITS);
    if (num < 0) ratio = -ratio;
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (cos_thresh[mid] >= ratio) lo = mid;
      else hi = mid - 1;
    end
    res.hue = lo[7:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, hues_checked);
    err_count++;
  endtask

  // One pixel transfer, with a random lead-in gap
  task automatic send_pixel(input logic [7:0] r, g, b, input logic lst, input bit gaps = 1);
    int gap;
    gap = gaps ? int'($urandom_range(0, 18)) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_red        <= r;
    in_green      <= g;
    in_blue       <= b;
    in_last_pixel <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hues.push_back(predict_hue(r, g, b, lst));
    pixels_sent++;
  endtask

  // Stop sending and wait until every expected result has come
  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_hues.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    hue_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_hues.size() == 0) begin
        report_mismatch("unexpected result", out_hue, 0);
      end else begin
        want = pending_hues.pop_front();
        if (out_hue !== want.hue) report_mismatch("hue", out_hue, want.hue);
        if (out_is_gray !== want.gray) report_mismatch("is_gray", out_is_gray, want.gray);
        if (out_last_out !== want.last) report_mismatch("last_out", out_last_out, want.last);
        if (want.gray) gray_seen++;
        hues_checked++;
      end
    end
  end

  // Directed: extremes, grays, primaries, ratio near +-1
  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd77, 8'd77, 8'd77, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd1, 1'b0);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd254, 1'b0);
    send_pixel(8'd128, 8'd127, 8'd129, 1'b0);
    send_pixel(8'd170, 8'd85, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd128, 8'd255, 1'b1);
    send_pixel(8'd85, 8'd170, 8'd255, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd100, 1'b0);
  endtask

  // Random: mix of near-gray, two-equal and free pixels
  task automatic test_random(input int count, input bit gaps);
    logic [7:0] r, g, b, base;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          base = 8'($urandom);
          r = base; g = base; b = base;
        end
        1: begin
          base = 8'($urandom);
          r = 8'(base + $urandom_range(0, 2));
          g = 8'(base + $urandom_range(0, 2));
          b = 8'(base + $urandom_range(0, 2));
        end
        2: begin
          r = 8'($urandom); g = 8'($urandom); b = g;
        end
        default: begin
          r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        end
      endcase
      send_pixel(r, g, b, 1'($urandom_range(0, 1)), gaps);
    end
  endtask

  // Back-to-back pixels after a full drain
  task automatic test_drain_then_burst();
    wait_drain();
    test_random(60, 1'b0);
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_red        = '0;
    in_green      = '0;
    in_blue       = '0;
    in_last_pixel = 1'b0;
    err_count     = 0;
    pixels_sent   = 0;
    hues_checked  = 0;
    gray_seen     = 0;
    for (int k = 0; k < rth_pkg::HUE_N; k++) cos_thresh[k] = cos_thresh_calc(k);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(220, 1'b1);
    test_drain_then_burst();
    test_random(200, 1'b1);

    wait_drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d pixels (%0d gray), directed extremes, gapped and burst traffic.",
             pixels_sent, gray_seen);
    $display("Checked %0d results with %0d mismatches.", hues_checked, err_count);
    if (err_count == 0 && pending_hues.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout waiting for results");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
